// ===== rtl/adls_pkg.sv =====
// ============================================================================
// adls_pkg
// Shared widths, register codes, fixed-point constants and types for the
// adaptive dual lowpass smoother.
// ============================================================================
package adls_pkg;

    localparam int CHANNELS      = 8;
    localparam int SAMPLE_BITS   = 24;
    localparam int CH_BITS       = 3;
    localparam int CH_ADDR_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // config port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int BASE_BITS     = 24;
    localparam int SENS_BITS     = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_RATIO  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SENSITIVITY = CFG_IDX_BITS'(1);

    localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(2097152);
    localparam logic [SENS_BITS-1:0] SENS_RESET = SENS_BITS'(8192);

    // cutoff ratio, Q.22
    localparam int WD_FRAC = 22;
    localparam int WD_BITS = WD_FRAC + 1;
    localparam logic [WD_BITS-1:0] WD_ONE = WD_BITS'(1) << WD_FRAC;

    // shared multiplier: A holds magnitude / wd / gain, B holds sensitivity,
    // polynomial terms and stage differences
    localparam int MUL_A_BITS = SAMPLE_BITS + 2;
    localparam int MUL_B_BITS = SENS_BITS + 1;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    localparam logic signed [MUL_B_BITS-1:0] POLY_C1 = MUL_B_BITS'(25144360);
    localparam logic signed [MUL_B_BITS-1:0] POLY_C2 = MUL_B_BITS'(-50202866);
    localparam logic signed [MUL_B_BITS-1:0] POLY_C3 = MUL_B_BITS'(66937158);

    // band product to Q.22
    localparam int SC_SHR = (SAMPLE_BITS >= 11) ? SAMPLE_BITS - 11 : 0;
    localparam int SC_SHL = (SAMPLE_BITS < 11) ? 11 - SAMPLE_BITS : 0;

    // gain Q.22 to Q.(SAMPLE_BITS-1)
    localparam int G_SHL = (SAMPLE_BITS - 1 >= WD_FRAC) ? SAMPLE_BITS - 1 - WD_FRAC : 0;
    localparam int G_SHR = (SAMPLE_BITS - 1 < WD_FRAC) ? WD_FRAC - (SAMPLE_BITS - 1) : 0;
    localparam logic [SAMPLE_BITS-1:0] G_ONE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] first_stage;
        logic signed [SAMPLE_BITS-1:0] second_stage;
        logic signed [SAMPLE_BITS-1:0] previous_input;
    } t_chan_state;

    localparam int STATE_BITS = $bits(t_chan_state);

endpackage

// ===== rtl/adls_in_if.sv =====
// ============================================================================
// adls_in_if
// Input sample channel: valid/ready handshake with tagged sample payload.
// ============================================================================
interface adls_in_if;
    logic                                    valid;
    logic                                    ready;
    logic        [adls_pkg::CH_BITS-1:0]     channel;
    logic signed [adls_pkg::SAMPLE_BITS-1:0] sample_in;
    logic                                    bypass;

    modport source (output valid, channel, sample_in, bypass, input ready);
    modport sink   (input valid, channel, sample_in, bypass, output ready);
endinterface

// ===== rtl/adls_out_if.sv =====
// ============================================================================
// adls_out_if
// Result channel: valid/ready handshake with channel tag and filtered sample.
// ============================================================================
interface adls_out_if;
    logic                                    valid;
    logic                                    ready;
    logic        [adls_pkg::CH_BITS-1:0]     out_channel;
    logic signed [adls_pkg::SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, out_channel, sample_out, input ready);
    modport sink   (input valid, out_channel, sample_out, output ready);
endinterface

// ===== rtl/adls_ram.sv =====
// ============================================================================
// adls_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module adls_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 8,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/adaptive_dual_lowpass_smoother.sv =====
// ============================================================================
// adaptive_dual_lowpass_smoother
// Per-channel adaptive two-pole smoothing filter over a shared state RAM.
// ============================================================================
// Usage:
//  - i_in (sink): one transfer carries channel, sample_in (signed Q1.23) and
//    bypass. ready is high only while the sequencer is idle.
//  - o_out (source): one transfer per input item with out_channel and
//    sample_out. The result sits in an output register, so the next input
//    is accepted while a finished result still waits to be taken.
//  - Config: i_cfg_we/i_cfg_idx/i_cfg_data write base_ratio (index 0) or
//    sensitivity (index 1); other indexes are ignored. Write
//    only while no item is in flight.
//  - Sequence: the state RAM is read at the transfer edge, six steps each
//    drive the single shared 26x33 multiplier once (band gain, cubic in
//    three steps, two stages) and a seventh writes back and loads the
//    result. ready returns as the result is loaded, so the chain is strictly
//    serial: no new item is taken until the last one is written back.
//  - Stall: if the previous result is still held at write-back, the
//    sequencer waits there; no state is written until the result moves.
//  - Reset: synchronous, active low. Control and config registers return to
//    their defaults and every channel reads as zero state through per-entry
//    valid bits, so no clearing pass is needed.
// ============================================================================
module adaptive_dual_lowpass_smoother (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [adls_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [adls_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    adls_in_if.sink                             i_in,
    adls_out_if.source                          o_out
);

    localparam int SB = adls_pkg::SAMPLE_BITS;
    localparam int MA = adls_pkg::MUL_A_BITS;
    localparam int MB = adls_pkg::MUL_B_BITS;
    localparam int MP = adls_pkg::MUL_P_BITS;
    localparam int WB = adls_pkg::WD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAND,   // state read back; |band| * sensitivity
        S_WD,     // wd; wd * C3
        S_T1,     // wd * (C2 + ...)
        S_T2,     // wd * (C1 + ...)
        S_G,      // clamp gain; g * (a - first_stage)
        S_L1,     // new first stage; g * (b - second_stage)
        S_WB      // new second stage, write back, present result
    } t_seq;

    // ---------------------------------------------------------------- regs
    t_seq                                  r_state, n_state;
    logic [adls_pkg::BASE_BITS-1:0]        r_base;
    logic [adls_pkg::SENS_BITS-1:0]        r_sens;
    logic [adls_pkg::CHANNELS-1:0]         r_valid;      // entry written since reset
    logic                                  r_rd_ok;
    logic [adls_pkg::CH_BITS-1:0]          r_ch;
    logic signed [SB-1:0]                  r_x;
    logic                                  r_byp;
    logic                                  r_inr;        // channel has state
    logic signed [SB-1:0]                  r_l1z, r_l2z, r_avg, r_l1;
    logic [WB-1:0]                         r_wd;
    logic [SB-1:0]                         r_g;
    logic signed [MP-1:0]                  r_prod, n_prod;
    logic                                  r_out_valid;
    logic [adls_pkg::CH_BITS-1:0]          r_out_ch;
    logic signed [SB-1:0]                  r_out_sample;

    // ---------------------------------------------------------------- RAM
    logic                                  in_xfer, out_free, wb_go, ram_we;
    logic [adls_pkg::CH_ADDR_BITS-1:0]     rd_addr, wr_addr;
    logic [adls_pkg::STATE_BITS-1:0]       ram_q;
    adls_pkg::t_chan_state                 rd_word, wr_word;
    logic                                  in_range;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign wb_go    = (r_state == S_WB) && out_free;
    assign ram_we   = wb_go && r_inr;
    assign rd_addr  = i_in.channel[adls_pkg::CH_ADDR_BITS-1:0];
    assign wr_addr  = r_ch[adls_pkg::CH_ADDR_BITS-1:0];
    assign in_range = ({1'b0, i_in.channel} < (adls_pkg::CH_BITS + 1)'(adls_pkg::CHANNELS));

    adls_ram #(
        .WIDTH (adls_pkg::STATE_BITS),
        .DEPTH (adls_pkg::CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_word),
        .i_re    (in_xfer),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // never-written entries read as zero
    assign rd_word = r_rd_ok ? adls_pkg::t_chan_state'(ram_q) : '0;

    // ------------------------------------------------------------ datapath
    logic signed [SB:0]          band, x_sum, diff1, b_sum, diff2;
    logic [SB:0]                 mag;
    logic signed [SB-1:0]        avg_new, b_avg, l1_new, l2_new;
    logic [MP-1:0]               sc_u;
    logic [WB-1:0]               sc_sat, wd_new;
    logic [adls_pkg::BASE_BITS:0] wd_sum;
    logic signed [MP-1:0]        prod_q22, step;
    logic signed [MB-1:0]        t_poly;
    logic [WB-1:0]               p_clamp;
    logic [SB-1:0]               g_new;
    logic signed [MA-1:0]        op_a;
    logic signed [MB-1:0]        op_b;

    always_comb begin
        // band magnitude and input average, straight from the RAM word
        band    = (SB + 1)'(rd_word.second_stage) - (SB + 1)'(rd_word.first_stage);
        mag     = band[SB] ? (SB + 1)'(-band) : (SB + 1)'(band);
        x_sum   = (SB + 1)'(r_x) + (SB + 1)'(rd_word.previous_input);
        avg_new = x_sum[SB:1];

        // wd = min(1, base + min(1, floor(|band| * sens)))
        sc_u   = (MP'(unsigned'(r_prod)) >> adls_pkg::SC_SHR) << adls_pkg::SC_SHL;
        sc_sat = (sc_u > MP'(adls_pkg::WD_ONE)) ? adls_pkg::WD_ONE : sc_u[WB-1:0];
        wd_sum = (adls_pkg::BASE_BITS + 1)'(r_base) + (adls_pkg::BASE_BITS + 1)'(sc_sat);
        wd_new = (wd_sum > (adls_pkg::BASE_BITS + 1)'(adls_pkg::WD_ONE)) ?
                 adls_pkg::WD_ONE : wd_sum[WB-1:0];

        // cubic, Horner form; arithmetic shift is the floor
        prod_q22 = r_prod >>> adls_pkg::WD_FRAC;
        t_poly   = (r_state == S_T1) ? adls_pkg::POLY_C2 : adls_pkg::POLY_C1;
        t_poly   = t_poly + signed'(prod_q22[MB-1:0]);

        if (prod_q22 < 0) begin
            p_clamp = '0;
        end else if (prod_q22 > MP'(adls_pkg::WD_ONE)) begin
            p_clamp = adls_pkg::WD_ONE;
        end else begin
            p_clamp = prod_q22[WB-1:0];
        end
        g_new = (SB'(p_clamp) << adls_pkg::G_SHL) >> adls_pkg::G_SHR;

        // stage updates
        step   = r_prod >>> (SB - 1);
        diff1  = (SB + 1)'(r_avg) - (SB + 1)'(r_l1z);
        l1_new = r_l1z + signed'(step[SB-1:0]);
        b_sum  = (SB + 1)'(l1_new) + (SB + 1)'(r_l1z);
        b_avg  = b_sum[SB:1];
        diff2  = (SB + 1)'(b_avg) - (SB + 1)'(r_l2z);
        l2_new = r_l2z + signed'(step[SB-1:0]);

        // shared multiplier operand select
        unique case (r_state)
            S_BAND: begin
                op_a = signed'(MA'(mag));
                op_b = signed'(MB'(r_sens));
            end
            S_WD: begin
                op_a = signed'(MA'(wd_new));
                op_b = adls_pkg::POLY_C3;
            end
            S_T1, S_T2: begin
                op_a = signed'(MA'(r_wd));
                op_b = t_poly;
            end
            S_G: begin
                op_a = signed'(MA'(g_new));
                op_b = MB'(diff1);
            end
            S_L1: begin
                op_a = signed'(MA'(r_g));
                op_b = MB'(diff2);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        n_prod = op_a * op_b;

        wr_word.first_stage    = r_l1;
        wr_word.second_stage   = l2_new;
        wr_word.previous_input = r_x;
    end

    // ------------------------------------------------------------ sequencer
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = in_xfer ? S_BAND : S_IDLE;
            S_BAND:  n_state = S_WD;
            S_WD:    n_state = S_T1;
            S_T1:    n_state = S_T2;
            S_T2:    n_state = S_G;
            S_G:     n_state = S_L1;
            S_L1:    n_state = S_WB;
            S_WB:    n_state = out_free ? S_IDLE : S_WB;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= adls_pkg::BASE_RESET;
            r_sens      <= adls_pkg::SENS_RESET;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == adls_pkg::CFG_BASE_RATIO) begin
                    r_base <= i_cfg_data[adls_pkg::BASE_BITS-1:0];
                end else if (i_cfg_idx == adls_pkg::CFG_SENSITIVITY) begin
                    r_sens <= i_cfg_data[adls_pkg::SENS_BITS-1:0];
                end
            end

            if (ram_we) begin
                r_valid[wr_addr] <= 1'b1;
            end

            if (wb_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload, no reset needed
        if (in_xfer) begin
            r_ch    <= i_in.channel;
            r_x     <= i_in.sample_in;
            r_byp   <= i_in.bypass;
            r_inr   <= in_range;
            r_rd_ok <= r_valid[rd_addr];
        end
        if (r_state == S_BAND) begin
            r_l1z <= rd_word.first_stage;
            r_l2z <= rd_word.second_stage;
            r_avg <= avg_new;
        end
        if (r_state == S_WD) begin
            r_wd <= wd_new;
        end
        if (r_state == S_G) begin
            r_g <= g_new;
        end
        if (r_state == S_L1) begin
            r_l1 <= l1_new;
        end
        if (r_state != S_IDLE && r_state != S_WB) begin
            r_prod <= n_prod;
        end
        if (wb_go) begin
            r_out_ch     <= r_ch;
            r_out_sample <= (r_inr && !r_byp) ? l2_new : r_x;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_ch;
    assign o_out.sample_out  = r_out_sample;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_BAND))
        else $error("accepted item did not start the sequence");

    a_wd_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T1) |-> (r_wd <= adls_pkg::WD_ONE))
        else $error("cutoff ratio above one");

    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_L1) |-> (r_g <= adls_pkg::G_ONE))
        else $error("gain above one");

    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_WB))
        else $error("result raised outside write-back");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_WB && r_inr))
        else $error("state written outside write-back");
`endif

endmodule
